// ===== hw/rtl/pfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the prime field arithmetic unit.
package pfm_pkg;

   localparam int ElemW = 30;        // field element width
   localparam int ExpW  = 31;        // exponent width
   localparam int CmdW  = 3;         // command code width
   localparam int MulW  = 31;        // shared multiplier operand width
   localparam int ProdW = 2 * MulW;  // shared multiplier product width
   localparam int DiffW = 32;        // Barrett remainder width, holds values below 3P

   localparam logic [ElemW-1:0] FieldP    = 30'd1000000007;
   localparam logic [ExpW-1:0]  FieldPm2  = 31'd1000000005;
   // floor(2^60 / P) for Barrett reduction of a 60-bit product
   localparam logic [MulW-1:0]  BarrettMu = 31'd1152921496;

   typedef enum logic [CmdW-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_NEG = 3'd4,
      CMD_INV = 3'd5,
      CMD_POW = 3'd6
   } cmd_type;

   // steps of one modular multiply on the shared multiplier
   typedef enum logic [2:0] {
      MM_IDLE,
      MM_PROD,
      MM_QUOT,
      MM_QP,
      MM_DIFF,
      MM_FIX
   } mm_step_type;

   // operand pair of a modular multiply; squaring writes base, the rest write acc
   typedef enum logic [1:0] {
      SRC_A_B,
      SRC_A_ACC,
      SRC_ACC_BASE,
      SRC_BASE_BASE
   } mm_src_type;

   typedef struct packed {
      logic        load;
      logic        alu;
      logic        pow_init;
      mm_step_type step;
      mm_src_type  src;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    a_zero;
      logic    b_zero;
      logic    exp_zero;
      logic    exp_lsb;
   } dp_status_type;

endpackage

// ===== hw/rtl/pfm_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: operand registers, add/sub unit, shared multiplier with Barrett reduction.
module pfm_dpath (
   input  logic                                 clock,
   input  logic [pfm_pkg::CmdW-1:0]             in_command,
   input  logic [pfm_pkg::ElemW-1:0]            in_operand_a,
   input  logic [pfm_pkg::ElemW-1:0]            in_operand_b,
   input  logic [pfm_pkg::ExpW-1:0]             in_exponent,
   input  pfm_pkg::dp_cmd_type                  ctl,
   output pfm_pkg::dp_status_type               stat,
   output logic [pfm_pkg::ElemW-1:0]            out_result,
   output logic                                 out_error
);

   localparam int ElemW = pfm_pkg::ElemW;
   localparam int ExpW  = pfm_pkg::ExpW;
   localparam int MulW  = pfm_pkg::MulW;
   localparam int ProdW = pfm_pkg::ProdW;
   localparam int DiffW = pfm_pkg::DiffW;
   localparam int TW    = 2 * ElemW;
   localparam logic [DiffW-1:0] PWide   = DiffW'(pfm_pkg::FieldP);
   localparam logic [DiffW-1:0] TwoPWide = PWide << 1;

   function automatic logic [ElemW-1:0] reduce_elem(input logic [ElemW-1:0] v);
      return (v >= pfm_pkg::FieldP) ? v - pfm_pkg::FieldP : v;
   endfunction

   pfm_pkg::cmd_type   cmd_ff, cmd_in;
   logic [ElemW-1:0]   a_ff, a_in;
   logic [ElemW-1:0]   b_ff, b_in;
   logic [ExpW-1:0]    exp_ff, exp_in;
   logic [ElemW-1:0]   acc_ff, acc_in;
   logic [ElemW-1:0]   base_ff, base_in;
   logic [TW-1:0]      t_ff, t_in;
   logic [ProdW-1:0]   mul_ff, mul_in;
   logic [DiffW-1:0]   diff_ff, diff_in;
   logic [ElemW-1:0]   result_ff, result_in;
   logic               error_ff, error_in;

   logic [ElemW-1:0]   src_x, src_y;
   logic [MulW-1:0]    mul_x, mul_y;
   logic [ProdW-1:0]   mul_p;
   logic [DiffW-1:0]   fixed;
   logic [ElemW:0]     sum;
   logic [ElemW-1:0]   alu_val;
   logic               err_cond;

   // operand pair of the current modular multiply
   always_comb begin
      src_x = a_ff;
      src_y = b_ff;
      case (ctl.src)
         pfm_pkg::SRC_A_B: begin
            src_x = a_ff;
            src_y = b_ff;
         end
         pfm_pkg::SRC_A_ACC: begin
            src_x = a_ff;
            src_y = acc_ff;
         end
         pfm_pkg::SRC_ACC_BASE: begin
            src_x = acc_ff;
            src_y = base_ff;
         end
         default: begin
            src_x = base_ff;
            src_y = base_ff;
         end
      endcase
   end

   // shared multiplier: product, then quotient estimate, then quotient times P
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (ctl.step)
         pfm_pkg::MM_PROD: begin
            mul_x = MulW'(src_x);
            mul_y = MulW'(src_y);
         end
         pfm_pkg::MM_QUOT: begin
            mul_x = t_ff[TW-1:ElemW-1];
            mul_y = pfm_pkg::BarrettMu;
         end
         pfm_pkg::MM_QP: begin
            mul_x = mul_ff[ProdW-1:MulW];
            mul_y = MulW'(pfm_pkg::FieldP);
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_p = mul_x * mul_y;

   // remainder is below 3P: subtract P at most twice
   always_comb begin
      if (diff_ff >= TwoPWide) begin
         fixed = diff_ff - TwoPWide;
      end else if (diff_ff >= PWide) begin
         fixed = diff_ff - PWide;
      end else begin
         fixed = diff_ff;
      end
   end

   // add, subtract, negate; unused command gives zero
   always_comb begin
      sum     = {1'b0, a_ff} + {1'b0, b_ff};
      alu_val = '0;
      case (cmd_ff)
         pfm_pkg::CMD_ADD: begin
            if (sum >= {1'b0, pfm_pkg::FieldP}) begin
               alu_val = ElemW'(sum - {1'b0, pfm_pkg::FieldP});
            end else begin
               alu_val = sum[ElemW-1:0];
            end
         end
         pfm_pkg::CMD_SUB: begin
            if (a_ff >= b_ff) begin
               alu_val = a_ff - b_ff;
            end else begin
               alu_val = ElemW'({1'b0, a_ff} + {1'b0, pfm_pkg::FieldP} - {1'b0, b_ff});
            end
         end
         pfm_pkg::CMD_NEG: begin
            alu_val = (a_ff == '0) ? '0 : pfm_pkg::FieldP - a_ff;
         end
         default: begin
            alu_val = '0;
         end
      endcase
   end

   assign err_cond = ((cmd_ff == pfm_pkg::CMD_DIV) && (b_ff == '0)) ||
                     ((cmd_ff == pfm_pkg::CMD_INV) && (a_ff == '0));

   always_comb begin
      cmd_in    = cmd_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      t_in      = t_ff;
      mul_in    = mul_ff;
      diff_in   = diff_ff;
      result_in = result_ff;
      error_in  = error_ff;

      if (ctl.load) begin
         cmd_in = pfm_pkg::cmd_type'(in_command);
         a_in   = reduce_elem(in_operand_a);
         b_in   = reduce_elem(in_operand_b);
         exp_in = in_exponent;
      end

      if (ctl.alu) begin
         acc_in = alu_val;
      end

      if (ctl.pow_init) begin
         acc_in  = ElemW'(1);
         base_in = (cmd_ff == pfm_pkg::CMD_DIV) ? b_ff : a_ff;
         exp_in  = (cmd_ff == pfm_pkg::CMD_POW) ? exp_ff : pfm_pkg::FieldPm2;
      end

      case (ctl.step) inside
         pfm_pkg::MM_PROD: begin
            t_in = mul_p[TW-1:0];
         end
         pfm_pkg::MM_QUOT, pfm_pkg::MM_QP: begin
            mul_in = mul_p;
         end
         pfm_pkg::MM_DIFF: begin
            diff_in = t_ff[DiffW-1:0] - mul_ff[DiffW-1:0];
         end
         pfm_pkg::MM_FIX: begin
            if (ctl.src == pfm_pkg::SRC_BASE_BASE) begin
               base_in = fixed[ElemW-1:0];
               exp_in  = exp_ff >> 1;
            end else begin
               acc_in  = fixed[ElemW-1:0];
               exp_in  = {exp_ff[ExpW-1:1], 1'b0};
            end
         end
         default: begin
         end
      endcase

      if (ctl.load_out) begin
         result_in = err_cond ? '0 : acc_ff;
         error_in  = err_cond;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      t_ff      <= t_in;
      mul_ff    <= mul_in;
      diff_ff   <= diff_in;
      result_ff <= result_in;
      error_ff  <= error_in;
   end

   assign stat.cmd      = cmd_ff;
   assign stat.a_zero   = (a_ff == '0);
   assign stat.b_zero   = (b_ff == '0);
   assign stat.exp_zero = (exp_ff == '0);
   assign stat.exp_lsb  = exp_ff[0];

   assign out_result = result_ff;
   assign out_error  = error_ff;

endmodule

// ===== hw/rtl/pfm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences commands, square-and-multiply and the modular multiply steps.
module pfm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   input  pfm_pkg::dp_status_type stat,
   output pfm_pkg::dp_cmd_type    ctl
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CHECK,
      ST_PROD,
      ST_QUOT,
      ST_QP,
      ST_DIFF,
      ST_FIX,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   pfm_pkg::mm_src_type src_ff, src_in;
   logic                last_ff, last_in;
   logic                valid_ff, valid_in;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      last_in      = last_ff;
      valid_in     = valid_ff && !out_ready;
      ctl          = '0;
      ctl.step     = pfm_pkg::MM_IDLE;
      ctl.src      = src_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               ctl.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.cmd)
               pfm_pkg::CMD_MUL: begin
                  src_in   = pfm_pkg::SRC_A_B;
                  last_in  = 1'b1;
                  state_in = ST_PROD;
               end
               pfm_pkg::CMD_DIV: begin
                  if (stat.b_zero) begin
                     state_in = ST_FINISH;
                  end else begin
                     ctl.pow_init = 1'b1;
                     state_in     = ST_CHECK;
                  end
               end
               pfm_pkg::CMD_INV: begin
                  if (stat.a_zero) begin
                     state_in = ST_FINISH;
                  end else begin
                     ctl.pow_init = 1'b1;
                     state_in     = ST_CHECK;
                  end
               end
               pfm_pkg::CMD_POW: begin
                  ctl.pow_init = 1'b1;
                  state_in     = ST_CHECK;
               end
               default: begin
                  ctl.alu  = 1'b1;
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_CHECK: begin
            // exponent used up: divide still needs the multiply by the dividend
            if (stat.exp_zero) begin
               if (stat.cmd == pfm_pkg::CMD_DIV) begin
                  src_in   = pfm_pkg::SRC_A_ACC;
                  last_in  = 1'b1;
                  state_in = ST_PROD;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (stat.exp_lsb) begin
               src_in   = pfm_pkg::SRC_ACC_BASE;
               last_in  = 1'b0;
               state_in = ST_PROD;
            end else begin
               src_in   = pfm_pkg::SRC_BASE_BASE;
               last_in  = 1'b0;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            ctl.step = pfm_pkg::MM_PROD;
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            ctl.step = pfm_pkg::MM_QUOT;
            state_in = ST_QP;
         end
         ST_QP: begin
            ctl.step = pfm_pkg::MM_QP;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            ctl.step = pfm_pkg::MM_DIFF;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            ctl.step = pfm_pkg::MM_FIX;
            state_in = last_ff ? ST_FINISH : ST_CHECK;
         end
         ST_FINISH: begin
            // hold until the output register is free or being drained
            if (!valid_ff || out_ready) begin
               ctl.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         src_ff   <= pfm_pkg::SRC_A_B;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = (state_ff == ST_IDLE);
   assign out_valid = valid_ff;

endmodule

// ===== hw/rtl/prime_field_mod_alu.sv =====
`timescale 1ns / 1ps
// Add, subtract, negate and error cases go from dispatch straight to the output register; multiply
// runs one modular multiply; power and inverse run square-and-multiply with at most 61 modular
// multiplies, and divide one more. Each modular multiply uses the single shared 31x31 multiplier
// in steps (product, Barrett quotient, quotient times P, two corrections).
// One item is in work at a time; the next beat is taken once the result sits in the output register.
// Synchronous active-high reset returns the controller to idle and empties the output register.
module prime_field_mod_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // command[2:0], operand_a[32:3], operand_b[62:33], exponent[93:63]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // result[29:0], error[30]
);

   pfm_pkg::dp_cmd_type            ctl;
   pfm_pkg::dp_status_type         stat;
   logic [pfm_pkg::ElemW-1:0]      out_result;
   logic                           out_error;

   pfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stat      (stat),
      .ctl       (ctl)
   );

   pfm_dpath u_dpath (
      .clock        (clock),
      .in_command   (req_tdata[2:0]),
      .in_operand_a (req_tdata[32:3]),
      .in_operand_b (req_tdata[62:33]),
      .in_exponent  (req_tdata[93:63]),
      .ctl          (ctl),
      .stat         (stat),
      .out_result   (out_result),
      .out_error    (out_error)
   );

   assign rsp_tdata = {1'b0, out_error, out_result};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an item is still in work");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over an undelivered beat");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_error_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[30]) |-> (rsp_tdata[29:0] == '0))
      else $error("error beat with nonzero result");

endmodule
